@@ rtl/fdia_pkg.sv @@
// Shared types, constants and helpers for the fence-deferred index allocator.
// Used by fdia_qcell and the top level; depends on nothing.
`default_nettype none
package fdia_pkg;

  localparam int POOL_DEPTH  = 256;
  localparam int QUEUE_DEPTH = 64;

  localparam int IDX_W   = 20;
  localparam int FENCE_W = 64;
  localparam int SIZE_W  = 9;
  localparam int POOL_AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int TOP_W   = $clog2(POOL_DEPTH + 1);
  localparam int QC_W    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_RETIRE  = 2'd2,
    CMD_COLLECT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_IGNORED   = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE    = 2'd0,
    S_POP     = 2'd1,
    S_COLLECT = 2'd2,
    S_DONE    = 2'd3
  } state_t;

  typedef enum logic {
    REG_FIRST_INDEX = 1'b0,
    REG_POOL_SIZE   = 1'b1
  } reg_t;

  typedef struct packed {
    logic [FENCE_W-1:0] fence;
    logic [IDX_W-1:0]   idx;
    logic               ivld;
  } qentry_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic take;
  } qctrl_t;

  function automatic logic [TOP_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    if (int'(s) > POOL_DEPTH) begin
      return TOP_W'(POOL_DEPTH);
    end
    return TOP_W'(s);
  endfunction

endpackage
`default_nettype wire

@@ rtl/fdia_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; holds the free stack of the allocator.
`default_nettype none
module fdia_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/fdia_qcell.sv @@
// One cell of the retire queue chain: holds one fence entry and hands it to
// its left neighbor during collect. Depends on fdia_pkg.
`default_nettype none
module fdia_qcell
  import fdia_pkg::*;
(
  input  wire logic clk,
  input  wire qctrl_t  ctrl,
  input  wire qentry_t new_entry,
  input  wire qentry_t right_entry,
  input  wire qentry_t head_entry,
  output qentry_t      entry
);

  qentry_t entry_r;
  qentry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.load) begin
      entry_nxt = new_entry;
    end else if (ctrl.shift) begin
      entry_nxt = ctrl.take ? head_entry : right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule
`default_nettype wire

@@ rtl/fence_deferred_index_allocator_unit.sv @@
// Top level of the fence-deferred index allocator: free stack, free bitmap,
// retire queue chain and control. Depends on fdia_pkg, fdia_ram, fdia_qcell.
//
// Release and retire, and acquire or collect that find nothing to do, give
// their result in the cycle after the transfer. Acquire passes through the
// pop and done states for the registered free-stack read. Collect walks the
// retire queue chain one entry per cycle. A new item is taken only when no
// earlier result waits, or in the cycle in which the waiting result is read
// out.
`default_nettype none
module fence_deferred_index_allocator_unit
  import fdia_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // index, fence
  input  wire logic [87:0] in_tdata,
  // command, has_index
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // granted_index, entries_collected, indexes_freed, free_count
  output logic [47:0]      out_tdata,
  // status
  output logic [1:0]       out_tuser,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  state_t state_r, state_nxt;
  logic [IDX_W-1:0]     first_r, first_nxt;
  logic [SIZE_W-1:0]    size_r, size_nxt;
  logic [TOP_W-1:0]     top_r, top_nxt;
  logic [QC_W-1:0]      qcount_r, qcount_nxt;
  logic [QC_W-1:0]      len_r, len_nxt;
  logic [QC_W-1:0]      steps_r, steps_nxt;
  logic [FENCE_W-1:0]   fence_r, fence_nxt;
  logic [QC_W-1:0]      coll_r, coll_nxt;
  logic [QC_W-1:0]      freed_r, freed_nxt;
  logic [IDX_W-1:0]     granted_r, granted_nxt;
  logic [POOL_AW-1:0]   k_r, k_nxt;
  logic                 svq_r, svq_nxt;
  logic [POOL_DEPTH-1:0] free_bits_r, free_bits_nxt;
  logic [POOL_DEPTH-1:0] sv_r, sv_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [47:0]          out_data_r, out_data_nxt;
  logic [1:0]           out_user_r, out_user_nxt;

  logic                 cfg_wr, accept, out_free, load_out, keep, last_step;
  logic [TOP_W-1:0]     n_eff, n_new;
  cmd_t                 cmd;
  logic [IDX_W-1:0]     in_idx, off, head_off, pop_val, pop_off;
  logic                 in_has;
  logic [FENCE_W-1:0]   in_fence;
  status_t              res_status;
  logic [IDX_W-1:0]     res_granted;
  logic [QC_W-1:0]      res_coll, res_freed;

  logic                 ram_we, ram_re;
  logic [POOL_AW-1:0]   ram_waddr, ram_raddr;
  logic [IDX_W-1:0]     ram_wdata, ram_rdata;

  qentry_t cell_q [QUEUE_DEPTH];
  qctrl_t  cell_ctrl [QUEUE_DEPTH];
  qentry_t new_entry;

  assign cmd      = cmd_t'(in_tuser[1:0]);
  assign in_has   = in_tuser[2];
  assign in_idx   = in_tdata[19:0];
  assign in_fence = in_tdata[83:20];
  assign n_eff    = eff_size(size_r);
  assign n_new    = eff_size(size_nxt);
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept   = in_tvalid && in_tready;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (reg_t'(cfg_paddr[2]) == REG_FIRST_INDEX) ?
                      {12'd0, first_r} : {23'd0, size_r};

  assign off      = in_idx - first_r;
  assign head_off = cell_q[0].idx - first_r;
  assign keep     = cell_q[0].fence > fence_r;
  assign last_step = (steps_r == QC_W'(1));
  assign pop_val  = svq_r ? ram_rdata :
                    (first_r + IDX_W'(n_eff) - IDX_W'(1) - IDX_W'(k_r));
  assign pop_off  = pop_val - first_r;

  assign new_entry.fence = in_fence;
  assign new_entry.idx   = in_has ? in_idx : '0;
  assign new_entry.ivld  = in_has;

  fdia_ram #(.WIDTH(IDX_W), .DEPTH(POOL_DEPTH)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    always_comb begin
      cell_ctrl[g].load  = accept && (cmd == CMD_RETIRE) &&
                           (qcount_r == QC_W'(g)) && (int'(qcount_r) < QUEUE_DEPTH);
      cell_ctrl[g].shift = (state_r == S_COLLECT);
      cell_ctrl[g].take  = keep && (len_r == QC_W'(g + 1));
    end
    fdia_qcell u_cell (
      .clk         (clk),
      .ctrl        (cell_ctrl[g]),
      .new_entry   (new_entry),
      .right_entry (cell_q[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
      .head_entry  (cell_q[0]),
      .entry       (cell_q[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (cmd == CMD_ACQUIRE && top_r != '0) begin
            state_nxt = S_POP;
          end else if (cmd == CMD_COLLECT && qcount_r != '0) begin
            state_nxt = S_COLLECT;
          end
        end
      end
      S_POP: state_nxt = S_DONE;
      S_COLLECT: begin
        if (last_step) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    first_nxt = first_r;
    size_nxt = size_r;
    top_nxt = top_r;
    qcount_nxt = qcount_r;
    len_nxt = len_r;
    steps_nxt = steps_r;
    fence_nxt = fence_r;
    coll_nxt = coll_r;
    freed_nxt = freed_r;
    granted_nxt = granted_r;
    k_nxt = k_r;
    svq_nxt = svq_r;
    free_bits_nxt = free_bits_r;
    sv_nxt = sv_r;
    ram_we = 1'b0;
    ram_re = 1'b0;
    ram_waddr = top_r[POOL_AW-1:0];
    ram_wdata = in_idx;
    ram_raddr = k_r;
    load_out = 1'b0;
    res_status = ST_OK;
    res_granted = '0;
    res_coll = '0;
    res_freed = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          case (cmd)
            CMD_ACQUIRE: begin
              if (top_r == '0) begin
                res_status = ST_EXHAUSTED;
              end else begin
                load_out = 1'b0;
                top_nxt = top_r - TOP_W'(1);
                k_nxt = top_nxt[POOL_AW-1:0];
                ram_re = 1'b1;
                ram_raddr = top_nxt[POOL_AW-1:0];
                svq_nxt = sv_r[top_nxt[POOL_AW-1:0]];
                coll_nxt = '0;
                freed_nxt = '0;
              end
            end
            CMD_RELEASE: begin
              if (off < IDX_W'(n_eff) && !free_bits_r[off[POOL_AW-1:0]]) begin
                ram_we = 1'b1;
                sv_nxt[top_r[POOL_AW-1:0]] = 1'b1;
                free_bits_nxt[off[POOL_AW-1:0]] = 1'b1;
                top_nxt = top_r + TOP_W'(1);
              end else begin
                res_status = ST_IGNORED;
              end
            end
            CMD_RETIRE: begin
              if (int'(qcount_r) >= QUEUE_DEPTH) begin
                res_status = ST_FULL;
              end else begin
                qcount_nxt = qcount_r + QC_W'(1);
              end
            end
            default: begin
              if (qcount_r != '0) begin
                load_out = 1'b0;
                fence_nxt = in_fence;
                len_nxt = qcount_r;
                steps_nxt = qcount_r;
                coll_nxt = '0;
                freed_nxt = '0;
                granted_nxt = '0;
              end
            end
          endcase
        end
      end
      S_POP: begin
        granted_nxt = pop_val;
        free_bits_nxt[pop_off[POOL_AW-1:0]] = 1'b0;
      end
      S_COLLECT: begin
        steps_nxt = steps_r - QC_W'(1);
        if (!keep) begin
          len_nxt = len_r - QC_W'(1);
          coll_nxt = coll_r + QC_W'(1);
          if (cell_q[0].ivld && head_off < IDX_W'(n_eff) &&
              !free_bits_r[head_off[POOL_AW-1:0]]) begin
            ram_we = 1'b1;
            ram_wdata = cell_q[0].idx;
            sv_nxt[top_r[POOL_AW-1:0]] = 1'b1;
            free_bits_nxt[head_off[POOL_AW-1:0]] = 1'b1;
            top_nxt = top_r + TOP_W'(1);
            freed_nxt = freed_r + QC_W'(1);
          end
        end
        if (last_step) begin
          qcount_nxt = len_nxt;
        end
      end
      S_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          res_granted = granted_r;
          res_coll = coll_r;
          res_freed = freed_r;
        end
      end
      default: begin
      end
    endcase

    if (cfg_wr) begin
      if (reg_t'(cfg_paddr[2]) == REG_FIRST_INDEX) begin
        first_nxt = cfg_pwdata[IDX_W-1:0];
      end else begin
        size_nxt = cfg_pwdata[SIZE_W-1:0];
      end
      top_nxt = eff_size(size_nxt);
      qcount_nxt = '0;
      sv_nxt = '0;
      for (int i = 0; i < POOL_DEPTH; i++) begin
        free_bits_nxt[i] = (TOP_W'(i) < n_new);
      end
    end

    out_valid_nxt = load_out ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
    out_data_nxt = out_data_r;
    out_user_nxt = out_user_r;
    if (load_out) begin
      out_user_nxt = res_status;
      out_data_nxt = {5'd0, 9'(top_nxt), 7'(res_freed), 7'(res_coll), res_granted};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      first_r <= '0;
      size_r <= 9'd256;
      top_r <= eff_size(9'd256);
      qcount_r <= '0;
      sv_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < POOL_DEPTH; i++) begin
        free_bits_r[i] <= (TOP_W'(i) < eff_size(9'd256));
      end
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
      size_r <= size_nxt;
      top_r <= top_nxt;
      qcount_r <= qcount_nxt;
      sv_r <= sv_nxt;
      out_valid_r <= out_valid_nxt;
      free_bits_r <= free_bits_nxt;
    end
    len_r <= len_nxt;
    steps_r <= steps_nxt;
    fence_r <= fence_nxt;
    coll_r <= coll_nxt;
    freed_r <= freed_nxt;
    granted_r <= granted_nxt;
    k_r <= k_nxt;
    svq_r <= svq_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire
